[src/gpo_pkg.sv]
package gpo_pkg;

    // map_mode codes
    localparam logic [1:0] MODE_TRINARY = 2'd0;
    localparam logic [1:0] MODE_SCALED  = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_MAP_MODE   = 3'd0;
    localparam logic [2:0] REG_INVERT     = 3'd1;
    localparam logic [2:0] REG_OCC_THRESH = 3'd2;
    localparam logic [2:0] REG_FREE_THRESH = 3'd3;
    localparam logic [2:0] REG_FULL_SCALE = 3'd4;

    // field and datapath widths
    localparam int PIX_W    = 8;
    localparam int THR_W    = 17;
    localparam int OCC_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int NUM_W    = PIX_W + 1;         // signed M - v or v
    localparam int PROD_W   = THR_W + PIX_W;     // threshold * M, Q1.16 scaled by M
    localparam int CMP_W    = PROD_W + 1;        // signed compare width
    localparam int DEN_W    = PROD_W + 1;        // 2 * d
    localparam int QUO_W    = 7;                 // quotient never exceeds 100
    localparam int REM_W    = PROD_W + 8;        // 198 * n + d
    localparam int DIV_STEPS = QUO_W;

    // reset values
    localparam logic [THR_W-1:0] OCC_THRESH_RST  = 17'd42598;
    localparam logic [THR_W-1:0] FREE_THRESH_RST = 17'd16384;
    localparam logic [PIX_W-1:0] FULL_SCALE_RST  = 8'd255;

    // occupancy codes
    localparam logic signed [OCC_W-1:0] OCC_UNKNOWN  = -8'sd1;
    localparam logic signed [OCC_W-1:0] OCC_FREE     = 8'sd0;
    localparam logic signed [OCC_W-1:0] OCC_MIN_MID  = 8'sd1;
    localparam logic signed [OCC_W-1:0] OCC_OCCUPIED = 8'sd100;

    // scale factors of the rounding divisions
    localparam int SCALE_MID = 198;  // 2 * 99
    localparam int SCALE_RAW = 200;  // 2 * 100

    // operands handed from the classify stage into the divider
    typedef struct packed {
        logic                          bypass;
        logic signed [OCC_W-1:0]       bypass_val;
        logic                          floor_one;
        logic [REM_W-1:0]              rem;
        logic [DEN_W-1:0]              den;
        logic [QUO_W-1:0]              quo;
    } div_stage_t;

endpackage

[src/gray_pixel_to_occupancy_top.sv]
// Throughput: one pixel per cycle while the output is not stalled; the pipeline is a multiply
// stage, a classify stage, seven one-bit restoring division stages and an output register.
// A stall on the output holds every stage in place.
// Reset (rst_n, async, active low) empties the pipeline and loads the default
// configuration: trinary mode, no inversion, thresholds 42598/16384, full scale 255.
module gray_pixel_to_occupancy_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [gpo_pkg::PIX_W-1:0]              pixel_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [gpo_pkg::OCC_W-1:0]       occupancy,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gpo_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gpo_pkg::CFG_DAT_W-1:0]          cfg_data
);

    // configuration registers
    logic [1:0]                    map_mode_reg;
    logic                          invert_reg;
    logic [gpo_pkg::THR_W-1:0]     occ_thresh_reg;
    logic [gpo_pkg::THR_W-1:0]     free_thresh_reg;
    logic [gpo_pkg::PIX_W-1:0]     full_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= gpo_pkg::MODE_TRINARY;
            invert_reg      <= 1'b0;
            occ_thresh_reg  <= gpo_pkg::OCC_THRESH_RST;
            free_thresh_reg <= gpo_pkg::FREE_THRESH_RST;
            full_scale_reg  <= gpo_pkg::FULL_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gpo_pkg::REG_MAP_MODE:    map_mode_reg    <= cfg_data[1:0];
                gpo_pkg::REG_INVERT:      invert_reg      <= cfg_data[0];
                gpo_pkg::REG_OCC_THRESH:  occ_thresh_reg  <= cfg_data[gpo_pkg::THR_W-1:0];
                gpo_pkg::REG_FREE_THRESH: free_thresh_reg <= cfg_data[gpo_pkg::THR_W-1:0];
                gpo_pkg::REG_FULL_SCALE:  full_scale_reg  <= cfg_data[gpo_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register is free or being drained
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: numerator and scaled thresholds ----------------
    logic [gpo_pkg::PIX_W-1:0]          m_eff;
    logic signed [gpo_pkg::NUM_W-1:0]   num_next;

    assign m_eff = (full_scale_reg == '0) ? gpo_pkg::PIX_W'(1) : full_scale_reg;

    always_comb
    begin
        if (invert_reg)
            num_next = $signed({1'b0, pixel_value});
        else
            num_next = $signed({1'b0, m_eff}) - $signed({1'b0, pixel_value});
    end

    logic                                s1_valid_reg;
    logic [1:0]                          s1_mode_reg;
    logic [gpo_pkg::PIX_W-1:0]           s1_m_reg;
    logic signed [gpo_pkg::NUM_W-1:0]    s1_num_reg;
    logic [gpo_pkg::PROD_W-1:0]          s1_occ_s_reg;
    logic [gpo_pkg::PROD_W-1:0]          s1_free_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg   <= map_mode_reg;
            s1_m_reg      <= m_eff;
            s1_num_reg    <= num_next;
            s1_occ_s_reg  <= gpo_pkg::PROD_W'(occ_thresh_reg) * gpo_pkg::PROD_W'(m_eff);
            s1_free_s_reg <= gpo_pkg::PROD_W'(free_thresh_reg) * gpo_pkg::PROD_W'(m_eff);
        end
    end

    // ---------------- stage 2: classify, set up the division ----------------
    logic signed [gpo_pkg::CMP_W-1:0]   pq_x;
    logic signed [gpo_pkg::CMP_W-1:0]   occ_x;
    logic signed [gpo_pkg::CMP_W-1:0]   free_x;
    logic signed [gpo_pkg::CMP_W-1:0]   span_d;
    logic signed [gpo_pkg::CMP_W-1:0]   span_n;
    logic                               gt_occ;
    logic                               lt_free;
    gpo_pkg::div_stage_t                s2_next;

    // p * 65536 * M is num shifted up by 16, sign extended to the compare width
    assign pq_x   = $signed({s1_num_reg[gpo_pkg::NUM_W-1], s1_num_reg, 16'b0});
    assign occ_x  = $signed({1'b0, s1_occ_s_reg});
    assign free_x = $signed({1'b0, s1_free_s_reg});
    assign span_d = occ_x - free_x;
    assign span_n = pq_x - free_x;
    assign gt_occ  = pq_x > occ_x;
    assign lt_free = pq_x < free_x;

    always_comb
    begin
        s2_next.bypass     = 1'b1;
        s2_next.bypass_val = gpo_pkg::OCC_UNKNOWN;
        s2_next.floor_one  = 1'b0;
        s2_next.rem        = '0;
        s2_next.den        = gpo_pkg::DEN_W'(1);
        s2_next.quo        = '0;
        unique case (s1_mode_reg)
            gpo_pkg::MODE_TRINARY:
            begin
                if (gt_occ)
                    s2_next.bypass_val = gpo_pkg::OCC_OCCUPIED;
                else if (lt_free)
                    s2_next.bypass_val = gpo_pkg::OCC_FREE;
            end
            gpo_pkg::MODE_SCALED:
            begin
                // between the thresholds: 0 <= n <= d here
                if (gt_occ)
                    s2_next.bypass_val = gpo_pkg::OCC_OCCUPIED;
                else if (lt_free)
                    s2_next.bypass_val = gpo_pkg::OCC_FREE;
                else if (span_d == '0)
                    s2_next.bypass_val = gpo_pkg::OCC_MIN_MID;
                else
                begin
                    s2_next.bypass    = 1'b0;
                    s2_next.floor_one = 1'b1;
                    s2_next.rem = gpo_pkg::REM_W'(span_n[gpo_pkg::PROD_W-1:0])
                                * gpo_pkg::REM_W'(gpo_pkg::SCALE_MID)
                                + gpo_pkg::REM_W'(span_d[gpo_pkg::PROD_W-1:0]);
                    s2_next.den = {span_d[gpo_pkg::PROD_W-1:0], 1'b0};
                end
            end
            gpo_pkg::MODE_RAW:
            begin
                if (s1_num_reg <= 0)
                    s2_next.bypass_val = gpo_pkg::OCC_FREE;
                else if (s1_num_reg >= $signed({1'b0, s1_m_reg}))
                    s2_next.bypass_val = gpo_pkg::OCC_OCCUPIED;
                else
                begin
                    // 0 < num < M, so the rounded percent stays at or below 100
                    s2_next.bypass = 1'b0;
                    s2_next.rem = gpo_pkg::REM_W'(s1_num_reg[gpo_pkg::PIX_W-1:0])
                                * gpo_pkg::REM_W'(gpo_pkg::SCALE_RAW)
                                + gpo_pkg::REM_W'(s1_m_reg);
                    s2_next.den = gpo_pkg::DEN_W'({s1_m_reg, 1'b0});
                end
            end
            default: ;
        endcase
    end

    logic                   s2_valid_reg;
    gpo_pkg::div_stage_t    s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    // ---------------- stages 3..9: restoring division, one quotient bit each ----------------
    logic                   div_valid_reg [gpo_pkg::DIV_STEPS];
    gpo_pkg::div_stage_t    div_reg       [gpo_pkg::DIV_STEPS];
    gpo_pkg::div_stage_t    div_next      [gpo_pkg::DIV_STEPS];

    for (genvar j = 0; j < gpo_pkg::DIV_STEPS; j++)
    begin : g_div
        localparam int SH = gpo_pkg::DIV_STEPS - 1 - j;
        gpo_pkg::div_stage_t    stg_in;
        logic                   stg_valid_in;
        logic [gpo_pkg::REM_W-1:0] trial;
        logic                   fits;

        if (j == 0)
        begin : g_first
            assign stg_in       = s2_reg;
            assign stg_valid_in = s2_valid_reg;
        end
        else
        begin : g_rest
            assign stg_in       = div_reg[j-1];
            assign stg_valid_in = div_valid_reg[j-1];
        end

        // quotient bits come MSB first and shift in at the bottom
        assign trial = gpo_pkg::REM_W'(stg_in.den) << SH;
        assign fits  = stg_in.rem >= trial;

        always_comb
        begin
            div_next[j]     = stg_in;
            div_next[j].quo = {stg_in.quo[gpo_pkg::QUO_W-2:0], fits};
            if (fits)
                div_next[j].rem = stg_in.rem - trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[j] <= 1'b0;
            else if (adv)
                div_valid_reg[j] <= stg_valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                div_reg[j] <= div_next[j];
        end
    end

    // ---------------- stage 10: final select into the output register ----------------
    gpo_pkg::div_stage_t                 last_stg;
    logic signed [gpo_pkg::OCC_W-1:0]    occ_next;
    logic signed [gpo_pkg::OCC_W-1:0]    occ_reg;

    assign last_stg = div_reg[gpo_pkg::DIV_STEPS-1];

    always_comb
    begin
        priority if (last_stg.bypass)
            occ_next = last_stg.bypass_val;
        else if (last_stg.floor_one && last_stg.quo == '0)
            occ_next = gpo_pkg::OCC_MIN_MID;
        else
            occ_next = $signed({1'b0, last_stg.quo});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid_reg[gpo_pkg::DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            occ_reg <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign occupancy = occ_reg;

`ifndef SYNTH
    // result always lies in the legal occupancy range
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy >= gpo_pkg::OCC_UNKNOWN && occupancy <= gpo_pkg::OCC_OCCUPIED))
        else $error("occupancy out of range");

    // a live division never starts with a zero divisor
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_reg.bypass) |-> (s2_reg.den != '0))
        else $error("division entered with zero divisor");

    // after the last step the remainder is below the divisor
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid_reg[gpo_pkg::DIV_STEPS-1] && !last_stg.bypass)
            |-> (last_stg.rem < gpo_pkg::REM_W'(last_stg.den)))
        else $error("division remainder not reduced");

    // a stall freezes the classify stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && s2_valid_reg) |=> (s2_valid_reg && $stable(s2_reg)))
        else $error("classify stage changed during stall");
`endif

endmodule
